/* hw/rtl/xld_pkg.sv */
// Shared types and constants for the XOR-linked deque.
// No dependencies; imported by xld_ram and xor_linked_deque_top.
package xld_pkg;

    localparam int NODES_DEF = 256;   // default node pool size, node 0 is null
    localparam int DATA_W    = 64;    // item width

    // Operation carried in the input tuser
    typedef enum logic [1:0] {
        OP_PUSH_HEAD = 2'd0,
        OP_PUSH_TAIL = 2'd1,
        OP_POP_HEAD  = 2'd2,
        OP_POP_TAIL  = 2'd3
    } t_op;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

/* hw/rtl/xld_ram.sv */
// Simple dual-port memory: one write port, one read port, registered read data.
// Depends on xld_pkg for the default data width.
module xld_ram
    import xld_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = NODES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/xor_linked_deque_top.sv */
// Top level of the XOR-linked deque: sequencer, end pointers, allocator, output register.
// Depends on xld_pkg and instantiates xld_ram for node items, node links and the free stack.
//
// Usage:
//   Input channel (s_axis_*): one item per operation. tuser carries the operation
//   (push head, push tail, pop head, pop tail), tdata the signed value to push
//   (ignored for pops).
//   Output channel (m_axis_*): exactly one result item per input item, in order.
//   tdata is the popped value (0 for pushes and failed pops); tuser carries the
//   status and a flag that is set when the list is empty after the operation.
//   Timing: the accepting edge reads the end node's item and link and the free
//   stack top; step 1 writes the new node or frees the old end, step 2 writes the
//   fixed-up neighbor link, the finish step loads the output register. A new item
//   is accepted only when the block is idle, after the finish step of the last one.
//   With no neighbor to fix (empty pop, refused push, push into an empty list, pop
//   of the last item) step 2 is skipped. Step 2 is needed for the link memory's
//   read-modify-write.
//   Reset empties both end pointers and the free stack and restarts the never-used
//   node counter at node 1; memory contents are kept and never used before written.
//   Stall: the result waits in the output register while m_axis_tready is low; the
//   block accepts and works the next item and holds in its finish step meanwhile.
module xor_linked_deque_top
    import xld_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [63:0] push_value
    input  logic [1:0]        s_axis_tuser,   // [1:0] op
    // result items
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [63:0] pop_value
    output logic [2:0]        m_axis_tuser    // [1:0] status, [2] now_empty
);

    localparam int IW = $clog2(NODES);   // node index width
    localparam int CW = IW + 1;          // counter width, holds NODES itself
    localparam logic [CW-1:0] NODES_C = CW'(NODES);
    localparam logic [IW-1:0] NULL_IDX = '0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP1,
        S_STEP2,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [DATA_W-1:0]   r_value, n_value;
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_fresh, n_fresh;
    logic [CW-1:0]       r_free_top, n_free_top;
    logic [IW-1:0]       r_fix_addr, n_fix_addr;
    logic [IW-1:0]       r_fix_xor, n_fix_xor;
    logic [DATA_W-1:0]   r_pop_val, n_pop_val;
    t_status             r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    t_status             r_out_status, n_out_status;
    logic                r_out_empty, n_out_empty;

    // memory ports
    logic              item_we;
    logic [IW-1:0]     item_waddr, item_raddr;
    logic [DATA_W-1:0] item_rdata;
    logic              link_we;
    logic [IW-1:0]     link_waddr, link_raddr, link_wdata, link_rdata;
    logic              fs_we;
    logic [IW-1:0]     fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    // decode helpers
    t_op           in_op;
    logic          in_head_side;
    logic          cur_head_side;
    logic          cur_pop;
    logic [IW-1:0] near_idx;
    logic [IW-1:0] nxt_idx;
    logic [IW-1:0] new_idx;
    logic          have_node;

    assign in_op         = t_op'(s_axis_tuser);
    assign in_head_side  = (in_op == OP_PUSH_HEAD) || (in_op == OP_POP_HEAD);
    assign cur_head_side = (r_op == OP_PUSH_HEAD) || (r_op == OP_POP_HEAD);
    assign cur_pop       = (r_op == OP_POP_HEAD) || (r_op == OP_POP_TAIL);
    assign near_idx      = cur_head_side ? r_head : r_tail;
    // an out-of-pool link reads as null
    assign nxt_idx       = ({1'b0, link_rdata} < NODES_C) ? link_rdata : NULL_IDX;

    // allocate from the free stack first, then from never-used nodes
    always_comb begin
        have_node = 1'b1;
        if (r_free_top != '0) begin
            new_idx = fs_rdata;
        end else if (r_fresh < NODES_C) begin
            new_idx = r_fresh[IW-1:0];
        end else begin
            new_idx   = NULL_IDX;
            have_node = 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_value      = r_value;
        n_head       = r_head;
        n_tail       = r_tail;
        n_fresh      = r_fresh;
        n_free_top   = r_free_top;
        n_fix_addr   = r_fix_addr;
        n_fix_xor    = r_fix_xor;
        n_pop_val    = r_pop_val;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_empty  = r_out_empty;

        item_we    = 1'b0;
        item_waddr = new_idx;
        item_raddr = near_idx;
        link_we    = 1'b0;
        link_waddr = r_fix_addr;
        link_wdata = link_rdata ^ r_fix_xor;
        link_raddr = r_fix_addr;
        fs_we      = 1'b0;
        fs_waddr   = r_free_top[IW-1:0];
        fs_wdata   = near_idx;
        fs_raddr   = r_free_top[IW-1:0] - IW'(1);

        // drop the result once the receiver takes it
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // read the end node's item and link, and the free stack top
                item_raddr = in_head_side ? r_head : r_tail;
                link_raddr = in_head_side ? r_head : r_tail;
                if (s_axis_tvalid) begin
                    n_op      = in_op;
                    n_value   = s_axis_tdata;
                    n_pop_val = '0;
                    n_status  = ST_OK;
                    n_state   = S_STEP1;
                end
            end

            S_STEP1: begin
                n_state = S_FINISH;
                if (!cur_pop) begin
                    if (!have_node) begin
                        n_status = ST_FULL;
                    end else begin
                        if (r_free_top != '0) begin
                            n_free_top = r_free_top - CW'(1);
                        end else begin
                            n_fresh = r_fresh + CW'(1);
                        end
                        item_we    = 1'b1;
                        link_we    = 1'b1;
                        link_waddr = new_idx;
                        link_wdata = near_idx;
                        // keep the old end's link in the read register for the fix-up
                        link_raddr = near_idx;
                        if (cur_head_side) begin
                            n_head = new_idx;
                        end else begin
                            n_tail = new_idx;
                        end
                        if (near_idx == NULL_IDX) begin
                            if (cur_head_side) begin
                                n_tail = new_idx;
                            end else begin
                                n_head = new_idx;
                            end
                        end else begin
                            n_fix_addr = near_idx;
                            n_fix_xor  = new_idx;
                            n_state    = S_STEP2;
                        end
                    end
                end else begin
                    if (near_idx == NULL_IDX) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_pop_val = item_rdata;
                        // free the old end node
                        fs_we      = 1'b1;
                        n_free_top = r_free_top + CW'(1);
                        link_raddr = nxt_idx;
                        if (cur_head_side) begin
                            n_head = nxt_idx;
                        end else begin
                            n_tail = nxt_idx;
                        end
                        if (nxt_idx == NULL_IDX) begin
                            if (cur_head_side) begin
                                n_tail = NULL_IDX;
                            end else begin
                                n_head = NULL_IDX;
                            end
                        end else begin
                            n_fix_addr = nxt_idx;
                            n_fix_xor  = near_idx;
                            n_state    = S_STEP2;
                        end
                    end
                end
            end

            S_STEP2: begin
                // fold the changed neighbor into the link of the old end (push) or of the new end (pop)
                link_we = 1'b1;
                n_state = S_FINISH;
            end

            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_pop_val;
                    n_out_status = r_status;
                    n_out_empty  = (r_head == NULL_IDX);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NULL_IDX;
            r_tail      <= NULL_IDX;
            r_fresh     <= CW'(1);
            r_free_top  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fresh     <= n_fresh;
            r_free_top  <= n_free_top;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_value      <= n_value;
        r_fix_addr   <= n_fix_addr;
        r_fix_xor    <= n_fix_xor;
        r_pop_val    <= n_pop_val;
        r_status     <= n_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_empty  <= n_out_empty;
    end

    xld_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODES),
        .AW    (IW)
    ) u_items (
        .i_clk   (i_clk),
        .i_we    (item_we),
        .i_waddr (item_waddr),
        .i_wdata (r_value),
        .i_raddr (item_raddr),
        .o_rdata (item_rdata)
    );

    xld_ram #(
        .WIDTH (IW),
        .DEPTH (NODES),
        .AW    (IW)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    xld_ram #(
        .WIDTH (IW),
        .DEPTH (NODES),
        .AW    (IW)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = {r_out_empty, r_out_status};

endmodule

/* tb/sv/tb_xor_linked_deque_top.sv */
// Self-checking bench for xor_linked_deque_top: random and directed push/pop items
// against a behavioral deque kept alongside the block, with random stalls on both sides.
// Depends on xld_pkg and the xor_linked_deque_top RTL.
module tb_xor_linked_deque_top;
    import xld_pkg::*;

    localparam int POOL       = NODES_DEF;   // node 0 is null, POOL-1 usable nodes
    localparam int CALM_ITEMS = 60;          // final stretch, in which no new idle gap starts

    typedef struct {
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_op_item;

    typedef struct {
        logic [DATA_W-1:0] value;
        t_status           st;
        logic              empty;
    } t_deque_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;   // [63:0] push_value
    logic [1:0]        s_axis_tuser = '0;   // [1:0] op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;        // [63:0] pop_value
    logic [2:0]        m_axis_tuser;        // [1:0] status, [2] now_empty

    xor_linked_deque_top #(.NODES(POOL)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Behavioral copy of the deque state
    logic [DATA_W-1:0] node_items [POOL];
    logic [7:0]        node_links [POOL];
    logic [7:0]        free_stack [POOL];
    logic [7:0]        head_idx  = '0;
    logic [7:0]        tail_idx  = '0;
    int                fresh_next = 1;
    int                free_top   = 0;

    t_op_item      pending_q [$];    // items still to be sent
    t_deque_result expected_q [$];   // results owed by the block, oldest first
    int            err_count = 0;
    int            depth_gen = 0;    // list depth as seen while building the stimulus
    bit            gen_done  = 1'b0;
    bit            in_taken  = 1'b0; // an input item was accepted at the last rising edge
    int            send_gap  = 0;
    int            recv_gap  = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Apply one operation to the behavioral deque and return the result it owes.
    task automatic deque_apply(input t_op op, input logic [DATA_W-1:0] val,
                               output t_deque_result r);
        logic [7:0] n;
        logic [7:0] old;
        logic [7:0] nxt;
        bit         got;
        r.value = '0;
        r.st    = ST_OK;
        if (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL) begin
            got = 1'b1;
            n   = '0;
            // take a freed node first, then a never-used one
            if (free_top > 0) begin
                free_top--;
                n = free_stack[free_top];
            end else if (fresh_next < POOL) begin
                n = fresh_next[7:0];
                fresh_next++;
            end else begin
                got = 1'b0;
            end
            if (!got) begin
                r.st = ST_FULL;
            end else begin
                node_items[n] = val;
                old = (op == OP_PUSH_HEAD) ? head_idx : tail_idx;
                node_links[n] = old;
                if (old == 0) begin
                    head_idx = n;
                    tail_idx = n;
                end else begin
                    node_links[old] = node_links[old] ^ n;
                    if (op == OP_PUSH_HEAD) head_idx = n;
                    else tail_idx = n;
                end
            end
        end else begin
            old = (op == OP_POP_HEAD) ? head_idx : tail_idx;
            if (old == 0) begin
                r.st = ST_EMPTY;
            end else begin
                r.value = node_items[old];
                nxt = node_links[old];
                if (op == OP_POP_HEAD) head_idx = nxt;
                else tail_idx = nxt;
                if (nxt == 0) begin
                    head_idx = '0;
                    tail_idx = '0;
                end else begin
                    node_links[nxt] = node_links[nxt] ^ old;
                end
                free_stack[free_top] = old;
                free_top++;
            end
        end
        r.empty = (head_idx == 0);
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch @%0t: %s got %h expected %h", $time, what, got, want);
        err_count++;
    endtask

    // Queue one operation and track the list depth it leaves behind.
    task automatic add_item(input t_op op, input logic [DATA_W-1:0] val);
        t_op_item it;
        it.op    = op;
        it.value = val;
        pending_q.push_back(it);
        if (op == OP_PUSH_HEAD || op == OP_PUSH_TAIL) begin
            if (depth_gen < POOL - 1) depth_gen++;
        end else if (depth_gen > 0) begin
            depth_gen--;
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DATA_W-1){1'b1}}};
            1:       return {1'b1, {(DATA_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_op rand_push();
        return $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
    endfunction

    function automatic t_op rand_pop();
        return $urandom_range(0, 1) ? OP_POP_TAIL : OP_POP_HEAD;
    endfunction

    // Stimulus: directed corners, balanced mix, fill to a full pool, then drain.
    initial begin
        // empty pops, then single-node lists drained from either end
        add_item(OP_POP_HEAD, '0);
        add_item(OP_POP_TAIL, '1);
        add_item(OP_PUSH_HEAD, {1'b0, {(DATA_W-1){1'b1}}});
        add_item(OP_POP_TAIL, '0);
        add_item(OP_PUSH_TAIL, {1'b1, {(DATA_W-1){1'b0}}});
        add_item(OP_POP_HEAD, '0);
        // build a short list from both ends and take it apart
        add_item(OP_PUSH_HEAD, '0);
        add_item(OP_PUSH_TAIL, '1);
        add_item(OP_PUSH_HEAD, 64'd1);
        add_item(OP_PUSH_TAIL, 64'h5555_5555_5555_5555);
        add_item(OP_PUSH_HEAD, 64'hAAAA_AAAA_AAAA_AAAA);
        add_item(OP_POP_HEAD, '0);
        add_item(OP_POP_TAIL, '0);
        add_item(OP_POP_TAIL, '0);
        add_item(OP_POP_HEAD, '0);
        add_item(OP_POP_HEAD, '0);
        add_item(OP_POP_TAIL, '0);

        // balanced mix near the empty list
        repeat (40) add_item(t_op'($urandom_range(0, 3)), rand_value());

        // fill the pool with a few pops mixed in
        while (depth_gen < POOL - 1) begin
            if (depth_gen > 0 && $urandom_range(0, 15) == 0) add_item(rand_pop(), rand_value());
            else add_item(rand_push(), rand_value());
        end
        // refused pushes around a full pool
        add_item(rand_push(), rand_value());
        add_item(rand_push(), rand_value());
        add_item(OP_POP_HEAD, rand_value());
        add_item(rand_push(), rand_value());
        add_item(rand_push(), rand_value());
        add_item(OP_POP_TAIL, rand_value());
        add_item(rand_push(), rand_value());
        add_item(rand_push(), rand_value());

        // drain, mostly pops
        repeat (60) begin
            if ($urandom_range(0, 99) < 85) add_item(rand_pop(), rand_value());
            else add_item(rand_push(), rand_value());
        end
        gen_done = 1'b1;
    end

    // Driver: change inputs on the falling edge.
    always @(negedge i_clk) begin
        t_op_item it;
        bit       calm;
        calm = gen_done && pending_q.size() < CALM_ITEMS;
        if (i_rst_n && gen_done) begin
            // sender: advance only when the current item is gone or none is shown
            if (!s_axis_tvalid || in_taken) begin
                if (send_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap--;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    send_gap = $urandom_range(1, 13) - 1;
                end else if (pending_q.size() > 0) begin
                    it = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= it.value;
                    s_axis_tuser  <= it.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            // receiver: stall in bursts, starting none in the final stretch
            if (recv_gap > 0) begin
                m_axis_tready <= 1'b0;
                recv_gap--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                recv_gap = $urandom_range(1, 13) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on each accepted input item, check each accepted result item.
    always @(posedge i_clk) begin
        t_deque_result r;
        t_deque_result want;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                deque_apply(t_op'(s_axis_tuser), s_axis_tdata, r);
                expected_q.push_back(r);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, tdata", m_axis_tdata, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata !== want.value)
                        report_mismatch("pop_value", m_axis_tdata, want.value);
                    if (m_axis_tuser[1:0] !== want.st)
                        report_mismatch("status", 64'(m_axis_tuser[1:0]), 64'(want.st));
                    if (m_axis_tuser[2] !== want.empty)
                        report_mismatch("now_empty", 64'(m_axis_tuser[2]), 64'(want.empty));
                end
            end
        end
    end

    // Reset, then wait for all items to go in and all results to come back.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!gen_done || pending_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/xld_pkg.sv
hw/rtl/xld_ram.sv
hw/rtl/xor_linked_deque_top.sv
tb/sv/tb_xor_linked_deque_top.sv
